// ----- hdl/ffca_pkg.sv -----
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared types and constants of the first-fit coalescing pool allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

  localparam int MAX_BLOCKS_DEF = 64;
  localparam int ADDR_W         = 32;
  localparam int SIZE_W         = 32;
  localparam int LEN_W          = 33;
  localparam int ALU_W          = 35;
  localparam int AMASK_W        = 15;
  localparam int ALIGN_W        = 4;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_LOG2 = 2'd2;

  localparam logic [ALIGN_W-1:0] ALIGN_RESET = 4'd8;
  localparam logic [LEN_W-1:0]   POOL_RESET  = 33'd1048576;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOFIT   = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_ROUND, S_OFFS,
    S_A_RD, S_A_CHK, S_A_USED, S_A_END, S_A_SPLIT, S_A_TOT, S_A_PEAK, S_A_RADDR,
    S_R_RD, S_R_WR,
    S_U_RD, S_U_CHK,
    S_F_ROUND, S_P_RD, S_P_CHK, S_F_MPREV, S_F_MNEXT, S_F_DEC, S_F_UMOV, S_F_ALLOC,
    S_F_M1, S_F_M2, S_I_RD, S_I_WR,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] off;
    logic [LEN_W-1:0]  len;
  } free_ent_t;

  typedef struct packed {
    logic [ADDR_W-1:0] off;
    logic [SIZE_W-1:0] len;
  } used_ent_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

endpackage

// ----- hdl/ffca_ram.sv -----
// ----------------------------------------------------------------------------
// ffca_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ffca_ram #(
  parameter int W = 8,
  parameter int D = 2
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- hdl/ffca_alu.sv -----
// ----------------------------------------------------------------------------
// ffca_alu
// Shared add/subtract unit; subtract reports a borrow for compares.
// ----------------------------------------------------------------------------
module ffca_alu (
  input  ffca_pkg::alu_req_t           req_i,
  output logic [ffca_pkg::ALU_W-1:0]   res_o,
  output logic                         borrow_o
);

  logic [ffca_pkg::ALU_W:0] sum;

  assign sum = {1'b0, req_i.a} + {1'b0, (req_i.sub ? ~req_i.b : req_i.b)}
             + {{ffca_pkg::ALU_W{1'b0}}, req_i.sub};
  assign res_o    = sum[ffca_pkg::ALU_W-1:0];
  assign borrow_o = req_i.sub & ~sum[ffca_pkg::ALU_W];

endmodule

// ----- hdl/first_fit_coalescing_allocator_top.sv -----
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator_top
// First-fit pool allocator with an address-ordered coalescing free table.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   kind, request_size, block_address
//   out      output     out_valid_o / out_stall_i status, addresses, sizes, counts
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// one request at a time; each table entry visited takes a read state then a check or write state (registered ram read)
// the scans and shifts run through one shared adder and one read port and one write port per table
// no clearing pass after reset; in_stall_o is high from acceptance until the result is taken
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator_top #(
  parameter int MAX_BLOCKS = ffca_pkg::MAX_BLOCKS_DEF,
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1),
  localparam int IDX_W = $clog2(MAX_BLOCKS)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        kind_i,
  input  logic [ffca_pkg::SIZE_W-1:0]       request_size_i,
  input  logic [ffca_pkg::ADDR_W-1:0]       block_address_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        status_o,
  output logic [ffca_pkg::ADDR_W-1:0]       result_address_o,
  output logic [ffca_pkg::SIZE_W-1:0]       block_size_o,
  output logic [ffca_pkg::LEN_W-1:0]        allocated_bytes_o,
  output logic [ffca_pkg::LEN_W-1:0]        peak_occupancy_o,
  output logic [CNT_W-1:0]                  free_blocks_o,
  output logic [CNT_W-1:0]                  used_blocks_o,
  input  logic                              cfg_we_i,
  input  logic [ffca_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ffca_pkg::LEN_W-1:0]        cfg_wdata_i
);

  localparam int AW = ffca_pkg::ADDR_W;
  localparam int SW = ffca_pkg::SIZE_W;
  localparam int LW = ffca_pkg::LEN_W;
  localparam int XW = ffca_pkg::ALU_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  ffca_pkg::state_e state_q, state_d;

  logic [AW-1:0]                 base_q, base_d;
  logic [LW-1:0]                 plen_q, plen_d;
  logic [ffca_pkg::ALIGN_W-1:0]  align_q, align_d;
  logic                          init0_q, init0_d;
  logic [CNT_W-1:0]              fcnt_q, fcnt_d, ucnt_q, ucnt_d;
  logic [LW-1:0]                 alloc_q, alloc_d, peak_q, peak_d;

  ffca_pkg::kind_e               kind_q, kind_d;
  logic [SW-1:0]                 req_q, req_d;
  logic [AW-1:0]                 addr_q, addr_d, off_q, off_d;
  logic [LW-1:0]                 need_q, need_d, rem_q, rem_d, tmp_q, tmp_d;
  logic [LW:0]                   end_q, end_d;
  logic [CNT_W-1:0]              idx_q, idx_d, u_q, u_d, j_q, j_d;
  logic [SW-1:0]                 ulen_q, ulen_d;
  logic [AW-1:0]                 head_q, head_d;
  ffca_pkg::free_ent_t           prev_q, prev_d, nxt_q, nxt_d;
  logic                          nvalid_q, nvalid_d, mprev_q, mprev_d, mnext_q, mnext_d;
  ffca_pkg::status_e             stat_q, stat_d;
  logic [AW-1:0]                 raddr_q, raddr_d;
  logic [SW-1:0]                 bsize_q, bsize_d;
  logic                          rd0_q;

  logic                          f_we;
  logic [IDX_W-1:0]              f_waddr, f_raddr;
  ffca_pkg::free_ent_t           f_wdata, f_rdata, f_data;
  logic                          u_we;
  logic [IDX_W-1:0]              u_waddr, u_raddr;
  ffca_pkg::used_ent_t           u_wdata, u_rdata;

  ffca_pkg::alu_req_t            alu;
  logic [XW-1:0]                 alu_res;
  logic                          alu_borrow;

  logic [ffca_pkg::AMASK_W-1:0]  amask;
  logic                          accept;
  logic [LW-1:0]                 cfg_len;

  assign amask   = ffca_pkg::AMASK_W'((16'd1 << align_q) - 16'd1);
  assign accept  = in_valid_i && !in_stall_o;
  assign cfg_len = cfg_wdata_i[LW-1] ? {1'b1, {(LW-1){1'b0}}} : cfg_wdata_i;
  assign f_data  = (rd0_q && init0_q) ? ffca_pkg::free_ent_t'{off: '0, len: plen_q} : f_rdata;

  ffca_ram #(.W($bits(ffca_pkg::free_ent_t)), .D(MAX_BLOCKS)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  ffca_ram #(.W($bits(ffca_pkg::used_ent_t)), .D(MAX_BLOCKS)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (u_we),
    .waddr_i (u_waddr),
    .wdata_i (u_wdata),
    .raddr_i (u_raddr),
    .rdata_o (u_rdata)
  );

  ffca_alu u_alu (
    .req_i    (alu),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  // shared adder operand select
  always_comb begin
    alu = '{a: '0, b: '0, sub: 1'b0};
    unique case (state_q)
      ffca_pkg::S_ROUND:   alu = '{a: XW'(req_q), b: XW'(amask), sub: 1'b0};
      ffca_pkg::S_F_ROUND: alu = '{a: XW'(ulen_q), b: XW'(amask), sub: 1'b0};
      ffca_pkg::S_OFFS:    alu = '{a: XW'(addr_q), b: XW'(base_q), sub: 1'b1};
      ffca_pkg::S_A_CHK:   alu = '{a: XW'(f_data.len), b: XW'(need_q), sub: 1'b1};
      ffca_pkg::S_A_END:   alu = '{a: XW'(head_q), b: XW'(need_q), sub: 1'b0};
      ffca_pkg::S_A_TOT:   alu = '{a: XW'(alloc_q), b: XW'(need_q), sub: 1'b0};
      ffca_pkg::S_A_PEAK:  alu = '{a: XW'(peak_q), b: XW'(end_q), sub: 1'b1};
      ffca_pkg::S_A_RADDR: alu = '{a: XW'(base_q), b: XW'(head_q), sub: 1'b0};
      ffca_pkg::S_F_MPREV: alu = '{a: XW'(prev_q.off), b: XW'(prev_q.len), sub: 1'b0};
      ffca_pkg::S_F_MNEXT: alu = '{a: XW'(off_q), b: XW'(need_q), sub: 1'b0};
      ffca_pkg::S_F_ALLOC: alu = '{a: XW'(alloc_q), b: XW'(need_q), sub: 1'b1};
      ffca_pkg::S_F_M1:
        alu = '{a: (mnext_q && !mprev_q) ? XW'(nxt_q.len) : XW'(prev_q.len),
                b: XW'(need_q), sub: 1'b0};
      ffca_pkg::S_F_M2:    alu = '{a: XW'(tmp_q), b: XW'(nxt_q.len), sub: 1'b0};
      default:             alu = '{a: '0, b: '0, sub: 1'b0};
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ffca_pkg::S_IDLE: begin
        if (accept) begin
          priority case (ffca_pkg::kind_e'(kind_i))
            ffca_pkg::KIND_ALLOC:
              state_d = (request_size_i == '0) ? ffca_pkg::S_OUT : ffca_pkg::S_ROUND;
            ffca_pkg::KIND_FREE, ffca_pkg::KIND_QUERY: state_d = ffca_pkg::S_OFFS;
            default: state_d = ffca_pkg::S_OUT;
          endcase
        end
      end
      ffca_pkg::S_ROUND:   state_d = ffca_pkg::S_A_RD;
      ffca_pkg::S_A_RD:
        state_d = (idx_q < fcnt_q) ? ffca_pkg::S_A_CHK : ffca_pkg::S_OUT;
      ffca_pkg::S_A_CHK: begin
        if (alu_borrow) state_d = ffca_pkg::S_A_RD;
        else if (ucnt_q >= CNT_MAX) state_d = ffca_pkg::S_OUT;
        else state_d = ffca_pkg::S_A_USED;
      end
      ffca_pkg::S_A_USED:  state_d = ffca_pkg::S_A_END;
      ffca_pkg::S_A_END:
        state_d = (rem_q != '0) ? ffca_pkg::S_A_SPLIT : ffca_pkg::S_R_RD;
      ffca_pkg::S_A_SPLIT: state_d = ffca_pkg::S_A_TOT;
      ffca_pkg::S_A_TOT:   state_d = ffca_pkg::S_A_PEAK;
      ffca_pkg::S_A_PEAK:  state_d = ffca_pkg::S_A_RADDR;
      ffca_pkg::S_A_RADDR: state_d = ffca_pkg::S_OUT;
      ffca_pkg::S_R_RD: begin
        if (j_q < fcnt_q) state_d = ffca_pkg::S_R_WR;
        else if (kind_q == ffca_pkg::KIND_ALLOC) state_d = ffca_pkg::S_A_TOT;
        else state_d = ffca_pkg::S_OUT;
      end
      ffca_pkg::S_R_WR:    state_d = ffca_pkg::S_R_RD;
      ffca_pkg::S_OFFS:    state_d = ffca_pkg::S_U_RD;
      ffca_pkg::S_U_RD:
        state_d = (idx_q < ucnt_q) ? ffca_pkg::S_U_CHK : ffca_pkg::S_OUT;
      ffca_pkg::S_U_CHK: begin
        if (u_rdata.off != off_q) state_d = ffca_pkg::S_U_RD;
        else if (kind_q == ffca_pkg::KIND_QUERY) state_d = ffca_pkg::S_OUT;
        else state_d = ffca_pkg::S_F_ROUND;
      end
      ffca_pkg::S_F_ROUND: state_d = ffca_pkg::S_P_RD;
      ffca_pkg::S_P_RD:
        state_d = (idx_q < fcnt_q) ? ffca_pkg::S_P_CHK : ffca_pkg::S_F_MPREV;
      ffca_pkg::S_P_CHK:
        state_d = (f_data.off <= off_q) ? ffca_pkg::S_P_RD : ffca_pkg::S_F_MPREV;
      ffca_pkg::S_F_MPREV: state_d = ffca_pkg::S_F_MNEXT;
      ffca_pkg::S_F_MNEXT: state_d = ffca_pkg::S_F_DEC;
      ffca_pkg::S_F_DEC: begin
        if (!mprev_q && !mnext_q && fcnt_q >= CNT_MAX) state_d = ffca_pkg::S_OUT;
        else state_d = ffca_pkg::S_F_UMOV;
      end
      ffca_pkg::S_F_UMOV:  state_d = ffca_pkg::S_F_ALLOC;
      ffca_pkg::S_F_ALLOC:
        state_d = (mprev_q || mnext_q) ? ffca_pkg::S_F_M1 : ffca_pkg::S_I_RD;
      ffca_pkg::S_F_M1:
        state_d = (mprev_q && mnext_q) ? ffca_pkg::S_F_M2 : ffca_pkg::S_OUT;
      ffca_pkg::S_F_M2:    state_d = ffca_pkg::S_R_RD;
      ffca_pkg::S_I_RD:
        state_d = (j_q > idx_q) ? ffca_pkg::S_I_WR : ffca_pkg::S_OUT;
      ffca_pkg::S_I_WR:    state_d = ffca_pkg::S_I_RD;
      ffca_pkg::S_OUT:     state_d = out_stall_i ? ffca_pkg::S_OUT : ffca_pkg::S_IDLE;
      default:             state_d = ffca_pkg::S_IDLE;
    endcase
  end

  // datapath and table access
  always_comb begin
    base_d = base_q;  plen_d = plen_q;  align_d = align_q;  init0_d = init0_q;
    fcnt_d = fcnt_q;  ucnt_d = ucnt_q;  alloc_d = alloc_q;  peak_d = peak_q;
    kind_d = kind_q;  req_d = req_q;    addr_d = addr_q;    off_d = off_q;
    need_d = need_q;  rem_d = rem_q;    tmp_d = tmp_q;      end_d = end_q;
    idx_d = idx_q;    u_d = u_q;        j_d = j_q;          ulen_d = ulen_q;
    head_d = head_q;  prev_d = prev_q;  nxt_d = nxt_q;      nvalid_d = nvalid_q;
    mprev_d = mprev_q; mnext_d = mnext_q;
    stat_d = stat_q;  raddr_d = raddr_q; bsize_d = bsize_q;
    f_we = 1'b0; f_waddr = idx_q[IDX_W-1:0]; f_wdata = '0; f_raddr = '0;
    u_we = 1'b0; u_waddr = ucnt_q[IDX_W-1:0]; u_wdata = '0; u_raddr = idx_q[IDX_W-1:0];

    unique case (state_q)
      ffca_pkg::S_IDLE: begin
        if (accept) begin
          kind_d  = ffca_pkg::kind_e'(kind_i);
          req_d   = request_size_i;
          addr_d  = block_address_i;
          idx_d   = '0;
          raddr_d = '0;
          bsize_d = '0;
          nvalid_d = 1'b0;
          priority case (ffca_pkg::kind_e'(kind_i))
            ffca_pkg::KIND_ALLOC:
              stat_d = (request_size_i == '0) ? ffca_pkg::ST_ZERO : ffca_pkg::ST_OK;
            ffca_pkg::KIND_FREE, ffca_pkg::KIND_QUERY: stat_d = ffca_pkg::ST_OK;
            default: stat_d = ffca_pkg::ST_UNKNOWN;
          endcase
        end
      end
      ffca_pkg::S_ROUND:   need_d = alu_res[LW-1:0] & ~LW'(amask);
      ffca_pkg::S_A_RD: begin
        f_raddr = idx_q[IDX_W-1:0];
        if (idx_q >= fcnt_q) stat_d = ffca_pkg::ST_NOFIT;
      end
      ffca_pkg::S_A_CHK: begin
        if (alu_borrow) begin
          idx_d = idx_q + CNT_ONE;
        end else if (ucnt_q >= CNT_MAX) begin
          stat_d = ffca_pkg::ST_FULL;
        end else begin
          head_d = f_data.off;
          rem_d  = alu_res[LW-1:0];
        end
      end
      ffca_pkg::S_A_USED: begin
        u_we    = 1'b1;
        u_waddr = ucnt_q[IDX_W-1:0];
        u_wdata = '{off: head_q, len: req_q};
        ucnt_d  = ucnt_q + CNT_ONE;
        bsize_d = req_q;
        j_d     = idx_q + CNT_ONE;
      end
      ffca_pkg::S_A_END:   end_d = alu_res[LW:0];
      ffca_pkg::S_A_SPLIT: begin
        f_we    = 1'b1;
        f_waddr = idx_q[IDX_W-1:0];
        f_wdata = '{off: end_q[AW-1:0], len: rem_q};
        if (idx_q == '0) init0_d = 1'b0;
      end
      ffca_pkg::S_A_TOT:   alloc_d = alu_res[LW-1:0];
      ffca_pkg::S_A_PEAK:  if (alu_borrow) peak_d = end_q[LW-1:0];
      ffca_pkg::S_A_RADDR: raddr_d = alu_res[AW-1:0];
      ffca_pkg::S_R_RD: begin
        f_raddr = j_q[IDX_W-1:0];
        if (j_q >= fcnt_q) fcnt_d = fcnt_q - CNT_ONE;
      end
      ffca_pkg::S_R_WR: begin
        f_we    = 1'b1;
        f_waddr = IDX_W'(j_q - CNT_ONE);
        f_wdata = f_data;
        if (j_q == CNT_ONE) init0_d = 1'b0;
        j_d     = j_q + CNT_ONE;
      end
      ffca_pkg::S_OFFS:    off_d = alu_res[AW-1:0];
      ffca_pkg::S_U_RD: begin
        u_raddr = idx_q[IDX_W-1:0];
        if (idx_q >= ucnt_q) stat_d = ffca_pkg::ST_UNKNOWN;
      end
      ffca_pkg::S_U_CHK: begin
        if (u_rdata.off != off_q) begin
          idx_d = idx_q + CNT_ONE;
        end else begin
          u_d    = idx_q;
          ulen_d = u_rdata.len;
          idx_d  = '0;
          if (kind_q == ffca_pkg::KIND_QUERY) begin
            raddr_d = addr_q;
            bsize_d = u_rdata.len;
          end
        end
      end
      ffca_pkg::S_F_ROUND: need_d = alu_res[LW-1:0] & ~LW'(amask);
      ffca_pkg::S_P_RD:    f_raddr = idx_q[IDX_W-1:0];
      ffca_pkg::S_P_CHK: begin
        if (f_data.off <= off_q) begin
          prev_d = f_data;
          idx_d  = idx_q + CNT_ONE;
        end else begin
          nxt_d    = f_data;
          nvalid_d = 1'b1;
        end
      end
      ffca_pkg::S_F_MPREV: mprev_d = (idx_q != '0) && (alu_res == XW'(off_q));
      ffca_pkg::S_F_MNEXT: mnext_d = nvalid_q && (alu_res == XW'(nxt_q.off));
      ffca_pkg::S_F_DEC: begin
        u_raddr = IDX_W'(ucnt_q - CNT_ONE);
        if (!mprev_q && !mnext_q && fcnt_q >= CNT_MAX) stat_d = ffca_pkg::ST_FULL;
      end
      ffca_pkg::S_F_UMOV: begin
        u_we    = 1'b1;
        u_waddr = u_q[IDX_W-1:0];
        u_wdata = u_rdata;
        ucnt_d  = ucnt_q - CNT_ONE;
        raddr_d = addr_q;
        bsize_d = ulen_q;
        j_d     = fcnt_q;
      end
      ffca_pkg::S_F_ALLOC: alloc_d = alu_borrow ? '0 : alu_res[LW-1:0];
      ffca_pkg::S_F_M1: begin
        tmp_d = alu_res[LW-1:0];
        if (mprev_q && !mnext_q) begin
          f_we    = 1'b1;
          f_waddr = IDX_W'(idx_q - CNT_ONE);
          f_wdata = '{off: prev_q.off, len: alu_res[LW-1:0]};
          if (idx_q == CNT_ONE) init0_d = 1'b0;
        end else if (mnext_q && !mprev_q) begin
          f_we    = 1'b1;
          f_waddr = idx_q[IDX_W-1:0];
          f_wdata = '{off: off_q, len: alu_res[LW-1:0]};
          if (idx_q == '0) init0_d = 1'b0;
        end
      end
      ffca_pkg::S_F_M2: begin
        f_we    = 1'b1;
        f_waddr = IDX_W'(idx_q - CNT_ONE);
        f_wdata = '{off: prev_q.off, len: alu_res[LW-1:0]};
        if (idx_q == CNT_ONE) init0_d = 1'b0;
        j_d     = idx_q + CNT_ONE;
      end
      ffca_pkg::S_I_RD: begin
        if (j_q > idx_q) begin
          f_raddr = IDX_W'(j_q - CNT_ONE);
        end else begin
          f_we    = 1'b1;
          f_waddr = idx_q[IDX_W-1:0];
          f_wdata = '{off: off_q, len: need_q};
          if (idx_q == '0) init0_d = 1'b0;
          fcnt_d  = fcnt_q + CNT_ONE;
        end
      end
      ffca_pkg::S_I_WR: begin
        f_we    = 1'b1;
        f_waddr = j_q[IDX_W-1:0];
        f_wdata = f_data;
        j_d     = j_q - CNT_ONE;
      end
      ffca_pkg::S_OUT: ;
      default: ;
    endcase

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        ffca_pkg::REG_POOL_BASE:  base_d = cfg_wdata_i[AW-1:0];
        ffca_pkg::REG_POOL_SIZE: begin
          plen_d  = cfg_len;
          init0_d = 1'b1;
          fcnt_d  = (cfg_len != '0) ? CNT_ONE : '0;
          ucnt_d  = '0;
          alloc_d = '0;
          peak_d  = '0;
        end
        ffca_pkg::REG_ALIGN_LOG2: align_d = cfg_wdata_i[ffca_pkg::ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffca_pkg::S_IDLE;
      base_q  <= '0;
      plen_q  <= ffca_pkg::POOL_RESET;
      align_q <= ffca_pkg::ALIGN_RESET;
      init0_q <= 1'b1;
      fcnt_q  <= CNT_ONE;
      ucnt_q  <= '0;
      alloc_q <= '0;
      peak_q  <= '0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      plen_q  <= plen_d;
      align_q <= align_d;
      init0_q <= init0_d;
      fcnt_q  <= fcnt_d;
      ucnt_q  <= ucnt_d;
      alloc_q <= alloc_d;
      peak_q  <= peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;   req_q <= req_d;     addr_q <= addr_d;   off_q <= off_d;
    need_q <= need_d;   rem_q <= rem_d;     tmp_q <= tmp_d;     end_q <= end_d;
    idx_q <= idx_d;     u_q <= u_d;         j_q <= j_d;         ulen_q <= ulen_d;
    head_q <= head_d;   prev_q <= prev_d;   nxt_q <= nxt_d;     nvalid_q <= nvalid_d;
    mprev_q <= mprev_d; mnext_q <= mnext_d;
    stat_q <= stat_d;   raddr_q <= raddr_d; bsize_q <= bsize_d;
    rd0_q <= (f_raddr == '0);
  end

  assign in_stall_o        = (state_q != ffca_pkg::S_IDLE);
  assign out_valid_o       = (state_q == ffca_pkg::S_OUT);
  assign status_o          = stat_q;
  assign result_address_o  = raddr_q;
  assign block_size_o      = bsize_q;
  assign allocated_bytes_o = alloc_q;
  assign peak_occupancy_o  = peak_q;
  assign free_blocks_o     = fcnt_q;
  assign used_blocks_o     = ucnt_q;

  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("request accepted while result pending");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fcnt_q <= CNT_MAX) && (ucnt_q <= CNT_MAX)) else $error("table count overflow");

  a_fail_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stat_q != ffca_pkg::ST_OK) |-> (raddr_q == '0 && bsize_q == '0))
    else $error("failed request carries address or size");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)))
    else $error("stalled result dropped or changed");

endmodule
